[sv/ssk_pkg.sv]
package ssk_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int KEY_W       = 32;
    localparam int TAG_W       = 16;
    localparam int REC_W       = KEY_W + TAG_W;

    typedef struct packed {
        logic [TAG_W-1:0]        tag;
        logic signed [KEY_W-1:0] key;
    } rec_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        rec_t             data;
    } wr_req_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } rd_req_t;

    typedef struct packed {
        logic valid;
        rec_t rec;
        logic last;
        logic ovf;
    } emit_t;

endpackage

[sv/selection_sort_by_key.sv]
// Loading takes one request per cycle; results appear only after the closing request.
// Each sorted position i of a batch of N scans entries i to N-1 through the single
// read port of the store, emits the smallest key and, when that entry was not at i,
// writes entry i back in its place. The first result leaves after the first scan.
// Reset is asynchronous and active low; it empties the batch and the output register.
// The record store is not cleared, as only entries of the current batch are read.
module selection_sort_by_key
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // energy_key[31:0], item_tag[47:32]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // sorted_key[31:0], sorted_tag[47:32]
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // overflow
);

    ssk_pkg::wr_req_t wr;
    ssk_pkg::rd_req_t rd;
    ssk_pkg::rec_t    rd_data;
    ssk_pkg::rec_t    in_rec;
    ssk_pkg::emit_t   emit;
    ssk_pkg::rec_t    out_rec_reg;
    logic             out_valid_reg;
    logic             out_last_reg;
    logic             out_ovf_reg;
    logic             out_free;

    assign in_rec.key = $signed(s_axis_tdata[ssk_pkg::KEY_W-1:0]);
    assign in_rec.tag = s_axis_tdata[ssk_pkg::REC_W-1:ssk_pkg::KEY_W];
    assign out_free   = !out_valid_reg || m_axis_tready;

    ssk_store u_store
    (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    ssk_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_rec   (in_rec),
        .in_last  (s_axis_tlast),
        .wr       (wr),
        .rd       (rd),
        .rd_data  (rd_data),
        .out_free (out_free),
        .emit     (emit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            out_rec_reg  <= emit.rec;
            out_last_reg <= emit.last;
            out_ovf_reg  <= emit.ovf;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_rec_reg.tag, out_rec_reg.key};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_ovf_reg;

endmodule

[sv/ssk_store.sv]
module ssk_store
(
    input  logic            clk,
    input  ssk_pkg::wr_req_t wr,
    input  ssk_pkg::rd_req_t rd,
    output ssk_pkg::rec_t    rd_data
);

    ssk_pkg::rec_t mem [ssk_pkg::MAX_ENTRIES];
    ssk_pkg::rec_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/ssk_ctrl.sv]
module ssk_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ssk_pkg::rec_t    in_rec,
    input  logic             in_last,
    output ssk_pkg::wr_req_t wr,
    output ssk_pkg::rd_req_t rd,
    input  ssk_pkg::rec_t    rd_data,
    input  logic             out_free,
    output ssk_pkg::emit_t   emit
);

    typedef enum logic [3:0] {
        S_LOAD = 4'b0001,
        S_SCAN = 4'b0010,
        S_EMIT = 4'b0100,
        S_SWAP = 4'b1000
    } state_t;

    state_t                     state_reg, state_next;
    logic [ssk_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       ovf_reg, ovf_next;
    logic [ssk_pkg::IDX_W-1:0]  pos_reg, pos_next;
    logic [ssk_pkg::CNT_W-1:0]  issue_reg, issue_next;
    logic                       pend_reg, pend_next;
    logic [ssk_pkg::IDX_W-1:0]  didx_reg, didx_next;
    logic [ssk_pkg::IDX_W-1:0]  best_idx_reg, best_idx_next;
    ssk_pkg::rec_t              best_reg, best_next;
    ssk_pkg::rec_t              cur_reg, cur_next;
    logic                       pos_is_last;

    assign pos_is_last = (ssk_pkg::CNT_W'(pos_reg) + ssk_pkg::CNT_W'(1)) == cnt_reg;
    assign in_ready    = (state_reg == S_LOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            pos_reg   <= '0;
            issue_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            pos_reg   <= pos_next;
            issue_reg <= issue_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        didx_reg     <= didx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        cur_reg      <= cur_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ovf_next      = ovf_reg;
        pos_next      = pos_reg;
        issue_next    = issue_reg;
        pend_next     = pend_reg;
        didx_next     = didx_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        cur_next      = cur_reg;
        wr            = '0;
        rd            = '0;
        emit          = '0;

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    if (cnt_reg < ssk_pkg::CNT_W'(ssk_pkg::MAX_ENTRIES))
                    begin
                        wr.en    = 1'b1;
                        wr.addr  = cnt_reg[ssk_pkg::IDX_W-1:0];
                        wr.data  = in_rec;
                        cnt_next = cnt_reg + ssk_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_last)
                    begin
                        state_next = S_SCAN;
                        pos_next   = '0;
                        issue_next = '0;
                        pend_next  = 1'b0;
                    end
                end
            end

            S_SCAN:
            begin
                if (issue_reg < cnt_reg)
                begin
                    rd.en      = 1'b1;
                    rd.addr    = issue_reg[ssk_pkg::IDX_W-1:0];
                    pend_next  = 1'b1;
                    didx_next  = issue_reg[ssk_pkg::IDX_W-1:0];
                    issue_next = issue_reg + ssk_pkg::CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    if (didx_reg == pos_reg)
                    begin
                        best_next     = rd_data;
                        cur_next      = rd_data;
                        best_idx_next = didx_reg;
                    end
                    else if ($signed(best_reg.key) > $signed(rd_data.key))
                    begin
                        best_next     = rd_data;
                        best_idx_next = didx_reg;
                    end
                    if ((ssk_pkg::CNT_W'(didx_reg) + ssk_pkg::CNT_W'(1)) == cnt_reg)
                    begin
                        state_next = S_EMIT;
                        pend_next  = 1'b0;
                    end
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    emit.valid = 1'b1;
                    emit.rec   = best_reg;
                    emit.last  = pos_is_last;
                    emit.ovf   = ovf_reg;
                    if (pos_is_last)
                    begin
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else if (best_idx_reg != pos_reg)
                    begin
                        state_next = S_SWAP;
                    end
                    else
                    begin
                        pos_next   = pos_reg + ssk_pkg::IDX_W'(1);
                        issue_next = ssk_pkg::CNT_W'(pos_reg) + ssk_pkg::CNT_W'(1);
                        pend_next  = 1'b0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SWAP:
            begin
                wr.en      = 1'b1;
                wr.addr    = best_idx_reg;
                wr.data    = cur_reg;
                pos_next   = pos_reg + ssk_pkg::IDX_W'(1);
                issue_next = ssk_pkg::CNT_W'(pos_reg) + ssk_pkg::CNT_W'(1);
                pend_next  = 1'b0;
                state_next = S_SCAN;
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= ssk_pkg::CNT_W'(ssk_pkg::MAX_ENTRIES))
        else $error("entry count exceeds capacity");

    a_scan_in_batch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (ssk_pkg::CNT_W'(pos_reg) < cnt_reg))
        else $error("sort position outside the stored batch");

    a_best_ahead: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (best_idx_reg >= pos_reg))
        else $error("selected entry lies before the sort position");

    a_batch_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (emit.valid && emit.last) |=> (cnt_reg == '0 && !ovf_reg))
        else $error("batch state not cleared after the final result");
`endif

endmodule
